// ----- src/fcc_pkg.sv -----
// Shared types and constants of the configurable Fletcher checksum block.
package fcc_pkg;

    localparam int SUM_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int DIGEST_W   = 32;
    localparam int DIV_W      = SUM_W + 1;
    localparam int STEP_CNT_W = $clog2(DIV_W);
    localparam int CFG_IDX_W  = 2;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIV_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SUM_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SUM_B = 2'd2;

    localparam logic [SUM_W-1:0] MODULUS_RESET    = 16'hFFFF;
    localparam logic [SUM_W-1:0] INIT_SUM_A_RESET = 16'h0000;
    localparam logic [SUM_W-1:0] INIT_SUM_B_RESET = 16'h0000;

    localparam logic FUNC_ABSORB  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic restart;
        logic load_a;
        logic step;
        logic commit_a;
        logic load_b;
        logic commit_b;
        logic send;
    } fcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } fcc_status_t;

endpackage

// ----- src/fcc_datapath.sv -----
// Datapath: configuration registers, running sums, restoring reducer and output register.
module fcc_datapath
    import fcc_pkg::*;
#(
    parameter int PART_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SUM_W-1:0]     cfg_wdata,
    input  logic [BYTE_W-1:0]    data_byte,
    input  fcc_cmd_t             cmd,
    output fcc_status_t          status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DIGEST_W-1:0]  m_tdata
);

    localparam int WIDE_W = DIGEST_W + PART_WIDTH + SUM_W;

    logic [SUM_W-1:0]    modulus_reg, modulus_next;
    logic [SUM_W-1:0]    init_a_reg, init_a_next;
    logic [SUM_W-1:0]    init_b_reg, init_b_next;
    logic [SUM_W-1:0]    sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]    sum_b_reg, sum_b_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIGEST_W-1:0] out_data_reg, out_data_next;

    logic [DIV_W-1:0]    r_shift;
    logic [DIV_W-1:0]    r_diff;
    logic                r_ge;
    logic [SUM_W-1:0]    rem_step;
    logic [DIV_W-1:0]    div_rot;
    logic [SUM_W-1:0]    reduced;
    logic [WIDE_W-1:0]   digest_wide;

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    // The dividend rotates, so after all steps it is back in place for the
    // zero-modulus bypass.
    assign r_shift  = {rem_reg, div_reg[DIV_W-1]};
    assign r_ge     = (r_shift >= {1'b0, modulus_reg});
    assign r_diff   = r_shift - {1'b0, modulus_reg};
    assign rem_step = r_ge ? r_diff[SUM_W-1:0] : r_shift[SUM_W-1:0];
    assign div_rot  = {div_reg[DIV_W-2:0], div_reg[DIV_W-1]};
    assign reduced  = (modulus_reg == '0) ? div_rot[SUM_W-1:0] : rem_step;

    assign digest_wide = ({{(WIDE_W-SUM_W){1'b0}}, sum_b_reg} << PART_WIDTH)
                       + {{(WIDE_W-SUM_W){1'b0}}, sum_a_reg};

    always_comb begin
        modulus_next   = modulus_reg;
        init_a_next    = init_a_reg;
        init_b_next    = init_b_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODULUS:    modulus_next = cfg_wdata;
                REG_INIT_SUM_A: init_a_next  = cfg_wdata;
                REG_INIT_SUM_B: init_b_next  = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.restart) begin
            sum_a_next = init_a_reg;
            sum_b_next = init_b_reg;
        end
        if (cmd.load_a) begin
            div_next = {1'b0, sum_a_reg} + {{(DIV_W-BYTE_W){1'b0}}, data_byte};
            rem_next = '0;
        end
        if (cmd.load_b) begin
            div_next = {1'b0, sum_a_reg} + {1'b0, sum_b_reg};
            rem_next = '0;
        end
        if (cmd.step) begin
            div_next = div_rot;
            rem_next = rem_step;
        end
        if (cmd.commit_a) begin
            sum_a_next = reduced;
        end
        if (cmd.commit_b) begin
            sum_b_next = reduced;
        end

        if (cmd.send) begin
            out_valid_next = 1'b1;
            out_data_next  = digest_wide[DIGEST_W-1:0];
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= MODULUS_RESET;
            init_a_reg    <= INIT_SUM_A_RESET;
            init_b_reg    <= INIT_SUM_B_RESET;
            sum_a_reg     <= INIT_SUM_A_RESET;
            sum_b_reg     <= INIT_SUM_B_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            modulus_reg   <= modulus_next;
            init_a_reg    <= init_a_next;
            init_b_reg    <= init_b_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    // A committed sum is a true remainder whenever the modulus is nonzero.
    a_sum_a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit_a && modulus_reg != '0) |=> (sum_a_reg < modulus_reg))
        else $error("sum A not reduced below modulus");

    a_sum_b_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit_b && modulus_reg != '0) |=> (sum_b_reg < modulus_reg))
        else $error("sum B not reduced below modulus");

    // The partial remainder never reaches the modulus between steps.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && modulus_reg != '0) |=> (rem_reg < modulus_reg))
        else $error("partial remainder out of range");

endmodule

// ----- src/fcc_ctrl.sv -----
// Controller: sequences acceptance, the two reductions and the digest hand-off.
module fcc_ctrl
    import fcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  fcc_status_t status,
    output fcc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RED_A  = 5'b00010,
        ST_LOAD_B = 5'b00100,
        ST_RED_B  = 5'b01000,
        ST_SEND   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_CNT_W-1:0] count_reg, count_next;
    logic                  eob_reg, eob_next;
    logic                  last_step;

    assign s_tready  = (state_reg == ST_IDLE);
    assign last_step = (count_reg == LAST_STEP);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        eob_next   = eob_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE: begin
                count_next = '0;
                if (s_tvalid) begin
                    if (s_tuser == FUNC_RESTART) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_SEND;
                    end else begin
                        cmd.load_a = 1'b1;
                        eob_next   = s_tlast;
                        state_next = ST_RED_A;
                    end
                end
            end
            ST_RED_A: begin
                cmd.step = 1'b1;
                if (last_step) begin
                    cmd.commit_a = 1'b1;
                    count_next   = '0;
                    state_next   = ST_LOAD_B;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_LOAD_B: begin
                cmd.load_b = 1'b1;
                state_next = ST_RED_B;
            end
            ST_RED_B: begin
                cmd.step = 1'b1;
                if (last_step) begin
                    cmd.commit_b = 1'b1;
                    count_next   = '0;
                    state_next   = eob_reg ? ST_SEND : ST_IDLE;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_SEND: begin
                if (status.out_free) begin
                    cmd.send   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            eob_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            eob_reg   <= eob_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_STEP)
        else $error("step counter overran");

    a_send_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.send |-> status.out_free)
        else $error("digest sent into a full output register");

    a_a_then_b: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_a |=> (state_reg == ST_LOAD_B))
        else $error("sum B reduction did not follow sum A");

endmodule

// ----- src/fletcher_checksum_configurable.sv -----
// Top level of the configurable Fletcher checksum block.
//
// The block keeps two running sums over a byte stream. An input request
// carries the data byte in s_tdata, the function in s_tuser (0 absorbs the
// byte, 1 restarts both sums from the init registers) and the end-of-block
// mark in s_tlast. Each absorbed byte updates A = (A + byte) mod modulus and
// then B = (A + B) mod modulus. A restart request, or an absorbed byte with
// s_tlast set, produces one output request whose m_tdata holds the digest
// (B shifted up by PART_WIDTH, plus A, kept to 32 bits).
// Both remainders are formed by one restoring reducer, one bit per cycle over
// a 17-bit dividend, and the second depends on the first. An absorbed byte
// therefore occupies the block through both reductions and, when it ends a
// block, the send state; a restart goes straight to the send state. The block
// takes one request at a time. The digest waits in an output register, so
// a stalled receiver does not stop the block from accepting and absorbing
// further bytes; only a new digest waits until the previous one has been taken.
// Reset returns the modulus to 65535 and both init values and sums to zero. The
// user must keep register writes (cfg_wr_en, cfg_index, cfg_wdata) to an idle
// block, not enforced by the block itself; index 0 is the modulus, 1 init A, 2 init B.
module fletcher_checksum_configurable
    import fcc_pkg::*;
#(
    parameter int PART_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SUM_W-1:0]     cfg_wdata,
    // Input request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] func
    input  logic                 s_tlast,
    // Digest channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DIGEST_W-1:0]  m_tdata    // [31:0] digest
);

    fcc_cmd_t    cmd;
    fcc_status_t status;

    // The controller decides on every cycle which datapath operation runs.
    fcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the sums, the reducer and the output stage.
    fcc_datapath #(
        .PART_WIDTH (PART_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
